// ===== sv/wms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wms_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int FRAME_SIZE_DEF = 256;
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 17;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh7fff;

  // (a*(1-w) + b*w) on offset-binary samples, rounded half up, saturated
  function automatic logic signed [SAMPLE_W-1:0] blend(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [WEIGHT_W-1:0] w
  );
    logic [SAMPLE_W-1:0] ua;
    logic [SAMPLE_W-1:0] ub;
    logic [33:0] acc;
    logic signed [17:0] r;
    ua = a ^ 16'h8000;
    ub = b ^ 16'h8000;
    acc = 34'(ua) * 34'(17'h10000 - w) + 34'(ub) * 34'(w) + 34'h8000;
    r = $signed({1'b0, acc[32:16]}) - 18'sd32768;
    if (r > 18'sd32767) begin
      blend = SAMPLE_MAX;
    end else if (r < -18'sd32767) begin
      blend = SAMPLE_MIN;
    end else begin
      blend = r[SAMPLE_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/wms_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wms_bank
  import wms_pkg::*;
#(
  parameter int AW = 13
) (
  input  wire                 clk,
  input  wire                 en,
  input  wire [AW-1:0]        raddr0,
  input  wire [AW-1:0]        raddr1,
  output logic [SAMPLE_W-1:0] rdata0,
  output logic [SAMPLE_W-1:0] rdata1,
  input  wire                 we,
  input  wire [AW-1:0]        waddr,
  input  wire [SAMPLE_W-1:0]  wdata
);

  logic [SAMPLE_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while the stage behind it is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

// ===== sv/wavetable_morph_sampler.sv =====
// pipeline: input register (stage a), then stages b, c and d, then the output register (stage e)
// throughput: one item per cycle while the output is not stalled; each frame store bank (even and odd slots) has
//   two read ports, so the four samples of a read are fetched at once
// writes land in the store as the item leaves stage b, before any later read
// reset: control and frame_count (to 1) clear; the frame store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module wavetable_morph_sampler
  import wms_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire [6:0]   cfg_data,    // frame_count
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire [79:0]  s_tdata,     // frame_index, sample_index, sample_value, phase, position
  input  wire [0:0]   s_tuser,     // cmd
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,     // out_sample
  output logic [0:0]  m_tuser      // status
);

  localparam int FW = $clog2(MAX_FRAMES);
  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int SW = $clog2(FRAME_SIZE);
  localparam int BW = FW + SW - 1;
  localparam int SCW = 17 + CW;

  logic [6:0] frame_count;
  logic [CW-1:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 7'd1;
    end else if (cfg_we) begin
      frame_count <= cfg_data;
    end
  end

  always_comb begin
    if (frame_count == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(frame_count) > MAX_FRAMES) begin
      n_eff = CW'(MAX_FRAMES);
    end else begin
      n_eff = CW'(frame_count);
    end
  end

  logic v_a, v_b, v_c, v_d;
  logic en_a, en_b, en_c, en_d, en_e;

  assign en_e = !m_tvalid || m_tready;
  assign en_d = !v_d || en_e;
  assign en_c = !v_c || en_d;
  assign en_b = !v_b || en_c;
  assign en_a = !v_a || en_b;
  assign s_tready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_a) v_a <= s_tvalid;
      if (en_b) v_b <= v_a;
      if (en_c) v_c <= v_b;
      if (en_d) v_d <= v_c;
      if (en_e) m_tvalid <= v_d;
    end
  end

  // stage a: input register
  logic a_cmd;
  logic [5:0] a_fi;
  logic [7:0] a_si;
  logic signed [15:0] a_sv;
  logic [31:0] a_phase;
  logic [16:0] a_pos;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_cmd <= s_tuser[0];
      a_fi <= s_tdata[5:0];
      a_si <= s_tdata[13:6];
      a_sv <= s_tdata[29:14];
      a_phase <= s_tdata[61:30];
      a_pos <= (s_tdata[78:62] > 17'h10000) ? 17'h10000 : s_tdata[78:62];
    end
  end

  // stage b: morph scale, sample slot, phase smoothstep first product, write check
  logic b_cmd;
  logic [SCW-1:0] b_sc;
  logic [CW-1:0] b_nm1;
  logic [SW-1:0] b_left;
  logic [31:0] b_mm;
  logic [17:0] b_t;
  logic b_wen, b_reject;
  logic [FW-1:0] b_wframe;
  logic [SW-1:0] b_wslot;
  logic signed [15:0] b_wdata;
  logic [15:0] a_m;

  assign a_m = a_phase[31-SW -: 16];

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_cmd <= a_cmd;
      b_nm1 <= n_eff - CW'(1);
      b_sc <= SCW'(a_pos) * SCW'(n_eff - CW'(1));
      b_left <= a_phase[31 -: SW];
      b_mm <= 32'(a_m) * 32'(a_m);
      b_t <= 18'd196608 - {1'b0, a_m, 1'b0};
      b_reject <= (a_cmd == CMD_WRITE) && (32'(a_fi) >= 32'(n_eff));
      b_wen <= (a_cmd == CMD_WRITE) && (32'(a_fi) < 32'(n_eff));
      b_wframe <= FW'(a_fi);
      b_wslot <= SW'(a_si);
      b_wdata <= (a_sv == 16'sh8000) ? SAMPLE_MIN : a_sv;
    end
  end

  // stage c: frame pick, store access, phase weight, morph smoothstep first product
  logic [CW:0] lo_raw, hi_raw;
  logic [FW-1:0] lo_f, hi_f;
  logic [SW-2:0] even_half, odd_half;
  logic [15:0] fr;

  always_comb begin
    lo_raw = b_sc[SCW-1:16];
    if (lo_raw > {1'b0, b_nm1}) lo_raw = {1'b0, b_nm1};
    hi_raw = lo_raw + (CW+1)'(1);
    if (hi_raw > {1'b0, b_nm1}) hi_raw = {1'b0, b_nm1};
    lo_f = FW'(lo_raw);
    hi_f = FW'(hi_raw);
    fr = b_sc[15:0];
    odd_half = b_left[SW-1:1];
    even_half = b_left[0] ? b_left[SW-1:1] + (SW-1)'(1) : b_left[SW-1:1];
  end

  logic store_we;
  logic [BW-1:0] waddr;
  logic [15:0] ev0, ev1, od0, od1;

  assign store_we = en_c && v_b && b_wen;
  assign waddr = {b_wframe, b_wslot[SW-1:1]};

  wms_bank #(.AW(BW)) u_even (
    .clk(clk), .en(en_c),
    .raddr0({lo_f, even_half}), .raddr1({hi_f, even_half}),
    .rdata0(ev0), .rdata1(ev1),
    .we(store_we && !b_wslot[0]), .waddr(waddr), .wdata(b_wdata)
  );

  wms_bank #(.AW(BW)) u_odd (
    .clk(clk), .en(en_c),
    .raddr0({lo_f, odd_half}), .raddr1({hi_f, odd_half}),
    .rdata0(od0), .rdata1(od1),
    .we(store_we && b_wslot[0]), .waddr(waddr), .wdata(b_wdata)
  );

  logic c_cmd, c_reject, c_swap;
  logic [WEIGHT_W-1:0] c_wm;
  logic [31:0] c_mmf;
  logic [17:0] c_tf;

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_cmd <= b_cmd;
      c_reject <= b_reject;
      c_swap <= b_left[0];
      c_wm <= WEIGHT_W'((50'(b_mm) * 50'(b_t) + 50'h8000_0000) >> 32);
      c_mmf <= 32'(fr) * 32'(fr);
      c_tf <= 18'd196608 - {1'b0, fr, 1'b0};
    end
  end

  // stage d: blend within each frame, morph weight
  logic signed [15:0] lo_l, lo_r, hi_l, hi_r;
  assign lo_l = c_swap ? od0 : ev0;
  assign lo_r = c_swap ? ev0 : od0;
  assign hi_l = c_swap ? od1 : ev1;
  assign hi_r = c_swap ? ev1 : od1;

  logic d_cmd, d_reject;
  logic signed [15:0] d_ra, d_rb;
  logic [WEIGHT_W-1:0] d_wf;

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_cmd <= c_cmd;
      d_reject <= c_reject;
      d_ra <= blend(lo_l, lo_r, c_wm);
      d_rb <= blend(hi_l, hi_r, c_wm);
      d_wf <= WEIGHT_W'((50'(c_mmf) * 50'(c_tf) + 50'h8000_0000) >> 32);
    end
  end

  // stage e: morph between frames into the output register
  always_ff @(posedge clk) begin
    if (en_e) begin
      m_tdata <= (d_cmd == CMD_READ) ? blend(d_ra, d_rb, d_wf) : 16'h0000;
      m_tuser[0] <= d_reject ? STATUS_REJECT : STATUS_OK;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] == STATUS_REJECT) |-> m_tdata == 16'h0000)
    else $error("rejected write item carries a nonzero sample");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata != 16'h8000)
    else $error("output sample not saturated");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && v_d && v_c && v_b && v_a |-> !s_tready)
    else $error("item taken while pipeline is full and stalled");

  a_write_gated: assert property (@(posedge clk) disable iff (rst)
    store_we |-> v_b && en_c && !b_reject)
    else $error("store written without a valid write item");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import wms_pkg::*;

  localparam int NFRM = 64;
  localparam int NSMP = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = 7'd1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0] m_tuser;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit written [NFRM*NSMP];

  wavetable_morph_sampler DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[wavetable_morph_sampler] ERROR");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  typedef struct packed {
    logic signed [15:0] smp;
    logic stat;
  } wave_result_t;

  class wave_scoreboard;
    logic signed [15:0] store [NFRM*NSMP];
    logic [6:0] count_reg;
    wave_result_t pending[$];

    function new();
      count_reg = 7'd1;
      foreach (store[i]) store[i] = '0;
    endfunction

    function int frames_in_use();
      int n;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > NFRM) n = NFRM;
      return n;
    endfunction

    function logic [16:0] smooth(input logic [15:0] m);
      logic [63:0] acc;
      acc = 64'(m) * 64'(m) * (64'd196608 - 64'd2 * 64'(m)) + 64'h80000000;
      return acc[48:32];
    endfunction

    function logic signed [15:0] mix(input logic signed [15:0] a,
                                     input logic signed [15:0] b,
                                     input logic [16:0] w);
      longint ua, ub, acc, r;
      ua = longint'(a) + 32768;
      ub = longint'(b) + 32768;
      acc = ua * (65536 - longint'(w)) + ub * longint'(w) + 32768;
      r = (acc >>> 16) - 32768;
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return 16'(r);
    endfunction

    function logic signed [15:0] frame_at(input int f, input logic [31:0] ph);
      logic [39:0] p;
      int lft, rgt;
      p = 40'(ph) * 40'(NSMP);
      lft = p[39:32];
      rgt = (lft + 1) % NSMP;
      return mix(store[f*NSMP+lft], store[f*NSMP+rgt], smooth(p[31:16]));
    endfunction

    function void note_item(input logic cmd, input logic [79:0] d);
      wave_result_t r;
      int n, lo, hi;
      logic signed [15:0] v;
      logic [31:0] sc;
      logic [16:0] pos;
      r = '0;
      n = frames_in_use();
      if (cmd == CMD_WRITE) begin
        v = d[29:14];
        if (v == -16'sd32768) v = -16'sd32767;
        if (d[5:0] >= n) r.stat = STATUS_REJECT;
        else store[d[5:0]*NSMP + d[13:6]] = v;
      end else begin
        pos = d[78:62];
        if (pos > 17'd65536) pos = 17'd65536;
        if (n <= 1) r.smp = frame_at(0, d[61:30]);
        else begin
          sc = 32'(pos) * 32'(n - 1);
          lo = sc[31:16];
          if (lo > n - 1) lo = n - 1;
          hi = lo + 1;
          if (hi > n - 1) hi = n - 1;
          r.smp = mix(frame_at(lo, d[61:30]), frame_at(hi, d[61:30]), smooth(sc[15:0]));
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(input logic [15:0] smp, input logic stat);
      wave_result_t w;
      if (pending.size() == 0) begin
        report("unexpected item", smp, 0);
        return;
      end
      w = pending.pop_front();
      if (smp !== w.smp) report("out_sample", $signed(smp), w.smp);
      if (stat !== w.stat) report("status", stat, w.stat);
    endtask
  endclass

  wave_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_item(s_tuser[0], s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
    m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // tvalid stays up after an accept; the next item or drain decides what follows
  task automatic send_item(input logic cmd, input logic [79:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [79:0] pack_write(input int f, input int s, input logic [15:0] v);
    return {1'b0, 17'd0, 32'd0, v, 8'(s), 6'(f)};
  endfunction

  function automatic logic [79:0] pack_read(input logic [31:0] ph, input logic [16:0] pos);
    return {1'b0, pos, ph, 16'd0, 8'd0, 6'd0};
  endfunction

  task automatic do_write(input int f, input int s, input logic [15:0] v);
    if (f < sb.frames_in_use()) written[f*NSMP+s] = 1'b1;
    send_item(CMD_WRITE, pack_write(f, s, v));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(input logic [6:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.count_reg = c;
  endtask

  // fill the four slots around the frame wrap; reads are steered onto them
  task automatic fill_frames(input int nf);
    int s;
    for (int f = 0; f < nf; f++)
      for (int k = 0; k < 4; k++) begin
        s = (NSMP - 2 + k) % NSMP;
        if (!written[f*NSMP+s]) do_write(f, s, 16'($urandom));
      end
  endtask

  // left slot is one of the last two or slot 0, so both neighbors are filled
  function automatic logic [31:0] rand_phase();
    logic [7:0] slot;
    slot = 8'(NSMP - 2 + $urandom_range(2));
    return {slot, 24'($urandom)};
  endfunction

  function automatic logic [16:0] rand_pos();
    case ($urandom_range(3))
      0: return 17'd65536;
      1: return 17'($urandom);
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic random_phase(input int nitems, input int nf);
    for (int i = 0; i < nitems; i++) begin
      if ($urandom_range(3) == 0)
        do_write($urandom_range(nf + 2 > 63 ? 63 : nf + 2), $urandom_range(255),
                 16'($urandom));
      else send_item(CMD_READ, pack_read(rand_phase(), rand_pos()));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single frame: extremes of sample values, phase and position, and rejected writes
    do_write(0, 0, 16'h8000);
    do_write(0, 255, 16'h7fff);
    do_write(0, 1, 16'h0000);
    do_write(1, 0, 16'h1234);
    do_write(63, 255, 16'hffff);
    fill_frames(1);
    send_item(CMD_READ, pack_read(32'd0, 17'd0));
    send_item(CMD_READ, pack_read(32'hffffffff, 17'h1ffff));
    send_item(CMD_READ, pack_read(32'h00ff8000, 17'd65536));
    send_item(CMD_READ, pack_read(32'hff800000, 17'd32768));
    send_item(CMD_READ, pack_read(32'h007fffff, 17'd65537));

    set_count(7'd0);
    send_item(CMD_READ, pack_read(32'h00345678, 17'd40000));
    do_write(1, 3, 16'h4000);
    set_count(7'd127);
    fill_frames(NFRM);
    do_write(63, 255, 16'h8000);
    send_item(CMD_READ, pack_read(32'hfff00000, 17'd65536));
    send_item(CMD_READ, pack_read(32'h00000000, 17'd0));
    send_item(CMD_READ, pack_read(32'hfe555555, 17'h1ffff));

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 60) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 36 : 60) : 0;
      case (ph)
        0: set_count(7'd2);
        1: set_count(7'd64);
        2: set_count(7'd1);
        default: set_count(7'(1 + $urandom_range(63)));
      endcase
      random_phase(45, sb.frames_in_use());
    end

    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        random_phase(40, sb.frames_in_use());
        drain();
      end
    join
    random_phase(20, sb.frames_in_use());

    drain();
    if (errors == 0) $display("[wavetable_morph_sampler] OK");
    else $display("[wavetable_morph_sampler] ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
sv/wms_pkg.sv
sv/wms_bank.sv
sv/wavetable_morph_sampler.sv
dv/testbench.sv
